@@ hdl/ilut_pkg.sv @@
package ilut_pkg;

  localparam int TABLE_DEPTH_DEF = 1024;

  localparam int IDX_W = 10;
  localparam int KEY_W = 48;
  localparam int VAL_W = 32;
  localparam int CNT_W = 11;
  localparam int IXW = CNT_W + 2;
  localparam int DIFF_W = VAL_W + 1;
  localparam int PROD_W = DIFF_W + KEY_W;
  localparam int HALF_W = KEY_W / 2;
  localparam int DIV_STEPS = 35;
  localparam int STEP_W = $clog2(DIV_STEPS);
  localparam int SUM_W = DIV_STEPS + 2;

  localparam int IN_DATA_W = 96;
  localparam int OUT_DATA_W = 32;

  localparam logic [CNT_W-1:0] CNT_MIN = CNT_W'(2);
  localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(2);

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef enum logic [1:0] {
    RANGE_INTERP = 2'd0,
    RANGE_BELOW  = 2'd1,
    RANGE_ABOVE  = 2'd2
  } range_t;

  typedef enum logic [1:0] {
    RD_BOUNDS,
    RD_SEARCH,
    RD_SEGMENT
  } rd_sel_t;

  typedef enum logic [1:0] {
    RES_FIRST,
    RES_LAST,
    RES_LEFT,
    RES_INTERP
  } res_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BND_RD,
    ST_BND_CHK,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_SEG_RD,
    ST_SEG_PREP,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_DIV_CHK,
    ST_DIV,
    ST_FINISH,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic     start;
    logic     wr_entry;
    logic     rd_en;
    rd_sel_t  rd_sel;
    logic     search_step;
    logic     seg_prep;
    logic     mul_lo;
    logic     mul_hi;
    logic     div_init;
    logic     div_step;
    logic     res_load;
    res_sel_t res_sel;
    logic     out_load;
  } ilut_cmd_t;

  typedef struct packed {
    logic below;
    logic above;
    logic found;
    logic search_end;
    logic seg_trivial;
    logic div_ovf;
    logic div_last;
    logic out_free;
  } ilut_stat_t;

endpackage

@@ hdl/interpolating_lookup_table.sv @@
// Channel   Direction  Content
// s_axis    in         tdata: entry_index, time_key, entry_value; tuser: func
// m_axis    out        tdata: result_value; tuser: range_status
// cfg       in         cfg_we, cfg_wdata: entry_count
//
// A write item is taken directly in the idle state. A clamped query ends after the bounds
// check, and a query inside the table runs a search in which each probe is a table read and a
// compare, then a 35-step divider, which is skipped when the quotient saturates.
// Reset is synchronous and clears the controller, the output valid flag and entry_count
// (to 2); the table memories are not cleared. A finished result waits in the output
// register while the next item runs; a second result holds the input until it is taken.
module interpolating_lookup_table #(
  parameter int TABLE_DEPTH = ilut_pkg::TABLE_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [ilut_pkg::CNT_W-1:0]          cfg_wdata,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // entry_index [9:0], time_key [57:10], entry_value [89:58], zero pad [95:90]
  input  logic [ilut_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // func [0]
  input  logic [0:0]                          s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // result_value [31:0]
  output logic [ilut_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  // range_status [1:0]
  output logic [1:0]                          m_axis_tuser
);

  localparam int IDX_W = ilut_pkg::IDX_W;
  localparam int KEY_W = ilut_pkg::KEY_W;
  localparam int VAL_W = ilut_pkg::VAL_W;

  ilut_pkg::ilut_cmd_t  cmd;
  ilut_pkg::ilut_stat_t stat;
  logic signed [VAL_W-1:0] result_value;

  ilut_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_func  (s_axis_tuser[0]),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ilut_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .entry_index  (s_axis_tdata[IDX_W-1:0]),
    .time_key     (s_axis_tdata[IDX_W+KEY_W-1:IDX_W]),
    .entry_value  (s_axis_tdata[IDX_W+KEY_W+VAL_W-1:IDX_W+KEY_W]),
    .cmd          (cmd),
    .stat         (stat),
    .out_ready    (m_axis_tready),
    .out_valid    (m_axis_tvalid),
    .result_value (result_value),
    .range_status (m_axis_tuser)
  );

  assign m_axis_tdata = result_value;

endmodule

@@ hdl/ilut_ctrl.sv @@
module ilut_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_func,
  output logic                in_ready,
  input  ilut_pkg::ilut_stat_t stat,
  output ilut_pkg::ilut_cmd_t  cmd
);

  ilut_pkg::state_t state;
  ilut_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ilut_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      ilut_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_func == ilut_pkg::FUNC_QUERY) begin
            cmd.start = 1'b1;
            state_next = ilut_pkg::ST_BND_RD;
          end else begin
            cmd.wr_entry = 1'b1;
          end
        end
      end
      ilut_pkg::ST_BND_RD: begin
        cmd.rd_en = 1'b1;
        cmd.rd_sel = ilut_pkg::RD_BOUNDS;
        state_next = ilut_pkg::ST_BND_CHK;
      end
      ilut_pkg::ST_BND_CHK: begin
        if (stat.below) begin
          cmd.res_load = 1'b1;
          cmd.res_sel = ilut_pkg::RES_FIRST;
          state_next = ilut_pkg::ST_OUT;
        end else if (stat.above) begin
          cmd.res_load = 1'b1;
          cmd.res_sel = ilut_pkg::RES_LAST;
          state_next = ilut_pkg::ST_OUT;
        end else begin
          state_next = ilut_pkg::ST_SRCH_RD;
        end
      end
      ilut_pkg::ST_SRCH_RD: begin
        cmd.rd_en = 1'b1;
        cmd.rd_sel = ilut_pkg::RD_SEARCH;
        state_next = ilut_pkg::ST_SRCH_CMP;
      end
      ilut_pkg::ST_SRCH_CMP: begin
        cmd.search_step = 1'b1;
        if (stat.found || stat.search_end) begin
          state_next = ilut_pkg::ST_SEG_RD;
        end else begin
          state_next = ilut_pkg::ST_SRCH_RD;
        end
      end
      ilut_pkg::ST_SEG_RD: begin
        cmd.rd_en = 1'b1;
        cmd.rd_sel = ilut_pkg::RD_SEGMENT;
        state_next = ilut_pkg::ST_SEG_PREP;
      end
      ilut_pkg::ST_SEG_PREP: begin
        cmd.seg_prep = 1'b1;
        if (stat.seg_trivial) begin
          cmd.res_load = 1'b1;
          cmd.res_sel = ilut_pkg::RES_LEFT;
          state_next = ilut_pkg::ST_OUT;
        end else begin
          state_next = ilut_pkg::ST_MUL_LO;
        end
      end
      ilut_pkg::ST_MUL_LO: begin
        cmd.mul_lo = 1'b1;
        state_next = ilut_pkg::ST_MUL_HI;
      end
      ilut_pkg::ST_MUL_HI: begin
        cmd.mul_hi = 1'b1;
        state_next = ilut_pkg::ST_DIV_CHK;
      end
      ilut_pkg::ST_DIV_CHK: begin
        cmd.div_init = 1'b1;
        if (stat.div_ovf) begin
          state_next = ilut_pkg::ST_FINISH;
        end else begin
          state_next = ilut_pkg::ST_DIV;
        end
      end
      ilut_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_next = ilut_pkg::ST_FINISH;
        end
      end
      ilut_pkg::ST_FINISH: begin
        cmd.res_load = 1'b1;
        cmd.res_sel = ilut_pkg::RES_INTERP;
        state_next = ilut_pkg::ST_OUT;
      end
      ilut_pkg::ST_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next = ilut_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = ilut_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

@@ hdl/ilut_dp.sv @@
module ilut_dp #(
  parameter int TABLE_DEPTH = ilut_pkg::TABLE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [ilut_pkg::CNT_W-1:0]       cfg_wdata,
  input  logic [ilut_pkg::IDX_W-1:0]       entry_index,
  input  logic [ilut_pkg::KEY_W-1:0]       time_key,
  input  logic signed [ilut_pkg::VAL_W-1:0] entry_value,
  input  ilut_pkg::ilut_cmd_t              cmd,
  output ilut_pkg::ilut_stat_t             stat,
  input  logic                             out_ready,
  output logic                             out_valid,
  output logic signed [ilut_pkg::VAL_W-1:0] result_value,
  output logic [1:0]                       range_status
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CNT_W = ilut_pkg::CNT_W;
  localparam int IXW = ilut_pkg::IXW;
  localparam int KEY_W = ilut_pkg::KEY_W;
  localparam int VAL_W = ilut_pkg::VAL_W;
  localparam int DIFF_W = ilut_pkg::DIFF_W;
  localparam int PROD_W = ilut_pkg::PROD_W;
  localparam int HALF_W = ilut_pkg::HALF_W;
  localparam int DIV_STEPS = ilut_pkg::DIV_STEPS;
  localparam int STEP_W = ilut_pkg::STEP_W;
  localparam int SUM_W = ilut_pkg::SUM_W;
  localparam logic [DIV_STEPS-1:0] Q_LIMIT = DIV_STEPS'(1) << (DIV_STEPS - 1);

  logic [KEY_W-1:0] key_mem [TABLE_DEPTH];
  logic [VAL_W-1:0] val_mem [TABLE_DEPTH];

  logic [CNT_W-1:0] entry_count;
  logic [CNT_W-1:0] n_clip;
  logic [CNT_W-1:0] n_eff;
  logic [CNT_W-1:0] nm1;
  logic [KEY_W-1:0] qtime;

  logic [KEY_W-1:0] krd0;
  logic [KEY_W-1:0] krd1;
  logic [VAL_W-1:0] vrd0;
  logic [VAL_W-1:0] vrd1;
  logic [CNT_W-1:0] ra0;
  logic [CNT_W-1:0] ra1;

  logic signed [IXW-1:0] lft;
  logic signed [IXW-1:0] rgt;
  logic [IXW-1:0] ix_sum;
  logic [CNT_W-1:0] mid_c;
  logic [CNT_W-1:0] mid;
  logic signed [IXW-1:0] lft_next;
  logic signed [IXW-1:0] rgt_next;
  logic go_left;
  logic found;
  logic [CNT_W-1:0] s0;
  logic [CNT_W-1:0] s1;

  logic signed [DIFF_W-1:0] dv;
  logic [DIFF_W-1:0] a_mag;
  logic [KEY_W-1:0] off_c;
  logic [KEY_W-1:0] w_c;
  logic t_before;
  logic k_desc;
  logic [DIFF_W-1:0] a;
  logic [KEY_W-1:0] off;
  logic [KEY_W-1:0] w;
  logic neg;
  logic signed [VAL_W-1:0] v1;

  logic [PROD_W-1:0] acc;
  logic acc_ovf;
  logic [KEY_W-1:0] rem;
  logic [KEY_W:0] rem_sh;
  logic rem_ge;
  logic [DIV_STEPS-1:0] quo;
  logic [STEP_W-1:0] step;
  logic ovf;
  logic [DIV_STEPS-1:0] q_clamp;
  logic signed [SUM_W-1:0] sum;
  logic signed [VAL_W-1:0] sat;

  logic signed [VAL_W-1:0] res_value;
  ilut_pkg::range_t res_status;

  always_comb begin
    n_clip = (entry_count < ilut_pkg::CNT_MIN) ? ilut_pkg::CNT_MIN : entry_count;
    n_eff = (32'(n_clip) > TABLE_DEPTH) ? CNT_W'(TABLE_DEPTH) : n_clip;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= ilut_pkg::CNT_RESET;
    end else if (cfg_we) begin
      entry_count <= cfg_wdata;
    end
  end

  assign ix_sum = IXW'(lft + rgt);
  assign mid_c = ix_sum[CNT_W:1];

  always_comb begin
    case (cmd.rd_sel)
      ilut_pkg::RD_BOUNDS: begin
        ra0 = '0;
        ra1 = nm1;
      end
      ilut_pkg::RD_SEARCH: begin
        ra0 = mid_c - CNT_W'(1);
        ra1 = mid_c;
      end
      ilut_pkg::RD_SEGMENT: begin
        ra0 = s0;
        ra1 = s1;
      end
      default: begin
        ra0 = s0;
        ra1 = s1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_entry && (32'(entry_index) < TABLE_DEPTH)) begin
      key_mem[AW'(entry_index)] <= time_key;
      val_mem[AW'(entry_index)] <= entry_value;
    end
    if (cmd.rd_en) begin
      krd0 <= key_mem[AW'(ra0)];
      krd1 <= key_mem[AW'(ra1)];
      vrd0 <= val_mem[AW'(ra0)];
      vrd1 <= val_mem[AW'(ra1)];
    end
  end

  always_comb begin
    found = (mid != '0) && (qtime >= krd0) && (qtime <= krd1);
    go_left = qtime < krd1;
    lft_next = go_left ? lft : IXW'({2'b00, mid}) + IXW'(1);
    rgt_next = go_left ? IXW'({2'b00, mid}) - IXW'(1) : rgt;
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      qtime <= time_key;
      nm1 <= n_eff - CNT_W'(1);
      lft <= '0;
      rgt <= IXW'({2'b00, n_eff}) - IXW'(1);
      s0 <= CNT_W'(0);
      s1 <= CNT_W'(1);
    end
    if (cmd.rd_en && (cmd.rd_sel == ilut_pkg::RD_SEARCH)) begin
      mid <= mid_c;
    end
    if (cmd.search_step) begin
      if (found) begin
        s0 <= mid - CNT_W'(1);
        s1 <= mid;
      end else begin
        lft <= lft_next;
        rgt <= rgt_next;
      end
    end
  end

  always_comb begin
    dv = DIFF_W'($signed(vrd1)) - DIFF_W'($signed(vrd0));
    a_mag = dv[DIFF_W-1] ? DIFF_W'(-dv) : DIFF_W'(dv);
    t_before = qtime < krd0;
    k_desc = krd1 < krd0;
    off_c = t_before ? krd0 - qtime : qtime - krd0;
    w_c = k_desc ? krd0 - krd1 : krd1 - krd0;
  end

  always_ff @(posedge clk) begin
    if (cmd.seg_prep) begin
      a <= a_mag;
      off <= off_c;
      w <= w_c;
      neg <= dv[DIFF_W-1] ^ t_before ^ k_desc;
      v1 <= vrd0;
    end
    if (cmd.mul_lo) begin
      acc <= PROD_W'(a * off[HALF_W-1:0]);
    end
    if (cmd.mul_hi) begin
      acc <= acc + (PROD_W'(a * off[KEY_W-1:HALF_W]) << HALF_W);
    end
  end

  assign acc_ovf = KEY_W'(acc[PROD_W-1:DIV_STEPS]) >= w;

  always_comb begin
    rem_sh = {rem, quo[DIV_STEPS-1]};
    rem_ge = rem_sh >= {1'b0, w};
  end

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem <= KEY_W'(acc[PROD_W-1:DIV_STEPS]);
      ovf <= acc_ovf;
      quo <= acc[DIV_STEPS-1:0];
      step <= '0;
    end
    if (cmd.div_step) begin
      rem <= rem_ge ? KEY_W'(rem_sh - {1'b0, w}) : rem_sh[KEY_W-1:0];
      quo <= {quo[DIV_STEPS-2:0], rem_ge};
      step <= step + STEP_W'(1);
    end
  end

  always_comb begin
    q_clamp = (ovf || (quo > Q_LIMIT)) ? Q_LIMIT : quo;
    sum = neg ? SUM_W'(v1) - SUM_W'({2'b00, q_clamp})
              : SUM_W'(v1) + SUM_W'({2'b00, q_clamp});
    if (sum > SUM_W'(signed'({1'b0, {(VAL_W-1){1'b1}}}))) begin
      sat = {1'b0, {(VAL_W-1){1'b1}}};
    end else if (sum < -SUM_W'(signed'({1'b0, {(VAL_W-1){1'b1}}})) - SUM_W'(1)) begin
      sat = {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      sat = sum[VAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      case (cmd.res_sel)
        ilut_pkg::RES_FIRST: begin
          res_value <= vrd0;
          res_status <= ilut_pkg::RANGE_BELOW;
        end
        ilut_pkg::RES_LAST: begin
          res_value <= vrd1;
          res_status <= ilut_pkg::RANGE_ABOVE;
        end
        ilut_pkg::RES_LEFT: begin
          res_value <= vrd0;
          res_status <= ilut_pkg::RANGE_INTERP;
        end
        default: begin
          res_value <= sat;
          res_status <= ilut_pkg::RANGE_INTERP;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      result_value <= res_value;
      range_status <= res_status;
    end
  end

  always_comb begin
    stat.below = qtime < krd0;
    stat.above = qtime > krd1;
    stat.found = found;
    stat.search_end = !found && (lft_next > rgt_next);
    stat.seg_trivial = (krd1 == krd0) || (dv == '0) || (qtime == krd0);
    stat.div_ovf = acc_ovf;
    stat.div_last = step == STEP_W'(DIV_STEPS - 1);
    stat.out_free = !out_valid || out_ready;
  end

endmodule
